// File: hdl/ssdps_pkg.sv
// Shared types, codes and start-line tables for the SSDP line splitter.
package ssdps_pkg;

    localparam int OUT_W = 11;
    localparam int DEFAULT_MAX_DATAGRAM_BYTES = 2048;
    localparam int START_TXT_MAX = 20;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_HEADERS = 2'd1,
        MODE_DONE    = 2'd2
    } parse_mode_t;

    localparam logic [1:0] KIND_START_OK     = 2'd0;
    localparam logic [1:0] KIND_HEADER       = 2'd1;
    localparam logic [1:0] KIND_START_REJECT = 2'd2;
    localparam logic [1:0] KIND_END          = 2'd3;

    localparam logic [1:0] MSG_NOTIFY          = 2'd0;
    localparam logic [1:0] MSG_SEARCH_REQUEST  = 2'd1;
    localparam logic [1:0] MSG_SEARCH_RESPONSE = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [19:0][7:0] TXT_NOTIFY   = {"NOTIFY * HTTP/1.1", 24'h000000};
    localparam logic [19:0][7:0] TXT_SEARCH   = {"M-SEARCH * HTTP/1.1", 8'h00};
    localparam logic [19:0][7:0] TXT_RESPONSE = {"HTTP/1.1 200 OK", 40'h0000000000};

    localparam logic [0:2][4:0] START_LEN = {5'd17, 5'd19, 5'd15};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       message_kind;
        logic [OUT_W-1:0] line_offset;
        logic [OUT_W-1:0] name_offset;
        logic [OUT_W-1:0] name_length;
        logic [OUT_W-1:0] value_offset;
        logic [OUT_W-1:0] value_length;
        logic             end_of_datagram;
    } out_t;

    typedef struct packed {
        logic made;
        out_t res;
    } step_t;

    function automatic logic [7:0] start_char(input logic [1:0] which, input logic [4:0] idx);
        logic [19:0][7:0] txt;
        unique case (which)
            MSG_NOTIFY:          txt = TXT_NOTIFY;
            MSG_SEARCH_REQUEST:  txt = TXT_SEARCH;
            MSG_SEARCH_RESPONSE: txt = TXT_RESPONSE;
            default:             txt = '0;
        endcase
        if (idx < 5'(START_TXT_MAX)) begin
            return txt[5'd19 - idx];
        end
        return 8'h00;
    endfunction

endpackage

// File: hdl/ssdps_line_parser.sv
// Line state and per-byte parsing step of the SSDP splitter.
module ssdps_line_parser #(
    parameter int MAX_DATAGRAM_BYTES = ssdps_pkg::DEFAULT_MAX_DATAGRAM_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ssdps_pkg::in_t    item,
    output ssdps_pkg::step_t  step
);

    localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);

    typedef struct packed {
        logic [2:0]       mask;
        logic             colon_seen;
        logic             name_found;
        logic [POS_W-1:0] name_first;
        logic [POS_W-1:0] name_last;
        logic             value_found;
        logic [POS_W-1:0] value_first;
        logic [POS_W-1:0] value_last;
    } line_t;

    localparam line_t LINE_CLEAR = '{mask: 3'b111, default: '0};

    ssdps_pkg::parse_mode_t mode_reg, mode_next;
    logic [1:0]       detected_reg, detected_next;
    logic [POS_W-1:0] offset_reg, offset_next;
    logic [POS_W-1:0] line_begin_reg, line_begin_next;
    logic             prev_cr_reg, prev_cr_next;
    line_t            line_reg, line_next;

    function automatic line_t take_content(input line_t st, input ssdps_pkg::parse_mode_t m,
                                           input logic [POS_W-1:0] lb, input logic [7:0] b,
                                           input logic [POS_W-1:0] p);
        line_t            r;
        logic [POS_W-1:0] rel;
        r   = st;
        rel = p - lb;
        if (m == ssdps_pkg::MODE_START) begin
            for (int i = 0; i < 3; i++) begin
                if (rel >= POS_W'(ssdps_pkg::START_LEN[i]) ||
                    ssdps_pkg::start_char(2'(i), rel[4:0]) != b) begin
                    r.mask[i] = 1'b0;
                end
            end
        end else if (m == ssdps_pkg::MODE_HEADERS) begin
            if (!st.colon_seen && b == ssdps_pkg::CHAR_COLON) begin
                r.colon_seen = 1'b1;
            end else if (b != ssdps_pkg::CHAR_SPACE && b != ssdps_pkg::CHAR_TAB) begin
                if (st.colon_seen) begin
                    if (!st.value_found) begin
                        r.value_found = 1'b1;
                        r.value_first = p;
                    end
                    r.value_last = p;
                end else begin
                    if (!st.name_found) begin
                        r.name_found = 1'b1;
                        r.name_first = p;
                    end
                    r.name_last = p;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] cr_pos;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] span;
        logic             closed;
        logic             hit;
        logic [1:0]       hit_kind;

        mode_next       = mode_reg;
        detected_next   = detected_reg;
        offset_next     = offset_reg;
        line_begin_next = line_begin_reg;
        prev_cr_next    = prev_cr_reg;
        line_next       = line_reg;
        step            = '0;
        pos             = offset_reg;
        cr_pos          = offset_reg - POS_W'(1);
        len             = cr_pos - line_begin_reg;
        span            = '0;
        closed          = 1'b0;
        hit             = 1'b0;
        hit_kind        = ssdps_pkg::MSG_NOTIFY;

        if (offset_reg < POS_W'(MAX_DATAGRAM_BYTES)) begin
            offset_next = offset_reg + POS_W'(1);
            if (prev_cr_reg) begin
                prev_cr_next = 1'b0;
                if (item.data_byte == ssdps_pkg::CHAR_LF) begin
                    closed = 1'b1;
                    step.res.line_offset = ssdps_pkg::OUT_W'(line_begin_reg);
                    if (mode_reg == ssdps_pkg::MODE_START) begin
                        for (int i = 0; i < 3; i++) begin
                            if (!hit && line_reg.mask[i] &&
                                len == POS_W'(ssdps_pkg::START_LEN[i])) begin
                                hit      = 1'b1;
                                hit_kind = 2'(i);
                            end
                        end
                        step.made = 1'b1;
                        if (hit) begin
                            detected_next          = hit_kind;
                            mode_next              = ssdps_pkg::MODE_HEADERS;
                            step.res.kind          = ssdps_pkg::KIND_START_OK;
                            step.res.message_kind  = hit_kind;
                        end else begin
                            mode_next              = ssdps_pkg::MODE_DONE;
                            step.res.kind          = ssdps_pkg::KIND_START_REJECT;
                            step.res.message_kind  = ssdps_pkg::MSG_NOTIFY;
                        end
                    end else if (mode_reg == ssdps_pkg::MODE_HEADERS) begin
                        if (len == '0) begin
                            mode_next = ssdps_pkg::MODE_DONE;
                            step.res  = '0;
                        end else begin
                            step.made             = 1'b1;
                            step.res.kind         = ssdps_pkg::KIND_HEADER;
                            step.res.message_kind = detected_reg;
                            if (line_reg.name_found) begin
                                span = line_reg.name_last - line_reg.name_first + POS_W'(1);
                                step.res.name_offset = ssdps_pkg::OUT_W'(line_reg.name_first);
                                step.res.name_length = ssdps_pkg::OUT_W'(span);
                            end else begin
                                step.res.name_offset = ssdps_pkg::OUT_W'(line_begin_reg);
                            end
                            if (line_reg.value_found) begin
                                span = line_reg.value_last - line_reg.value_first + POS_W'(1);
                                step.res.value_offset = ssdps_pkg::OUT_W'(line_reg.value_first);
                                step.res.value_length = ssdps_pkg::OUT_W'(span);
                            end else begin
                                step.res.value_offset = ssdps_pkg::OUT_W'(cr_pos);
                            end
                        end
                    end else begin
                        step.res = '0;
                    end
                    line_begin_next = pos + POS_W'(1);
                    line_next       = LINE_CLEAR;
                end else begin
                    line_next = take_content(line_reg, mode_reg, line_begin_reg,
                                             ssdps_pkg::CHAR_CR, cr_pos);
                end
            end
            if (!closed) begin
                if (item.data_byte == ssdps_pkg::CHAR_CR) begin
                    prev_cr_next = 1'b1;
                end else begin
                    line_next = take_content(line_next, mode_reg, line_begin_reg,
                                             item.data_byte, pos);
                end
            end
        end

        if (item.last_byte) begin
            if (!step.made) begin
                step.made             = 1'b1;
                step.res              = '0;
                step.res.kind         = ssdps_pkg::KIND_END;
                step.res.message_kind = detected_reg;
            end
            step.res.end_of_datagram = 1'b1;
            mode_next       = ssdps_pkg::MODE_START;
            detected_next   = ssdps_pkg::MSG_NOTIFY;
            offset_next     = '0;
            line_begin_next = '0;
            prev_cr_next    = 1'b0;
            line_next       = LINE_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ssdps_pkg::MODE_START;
            detected_reg   <= ssdps_pkg::MSG_NOTIFY;
            offset_reg     <= '0;
            line_begin_reg <= '0;
            prev_cr_reg    <= 1'b0;
            line_reg       <= LINE_CLEAR;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            detected_reg   <= detected_next;
            offset_reg     <= offset_next;
            line_begin_reg <= line_begin_next;
            prev_cr_reg    <= prev_cr_next;
            line_reg       <= line_next;
        end
    end

endmodule

// File: hdl/ssdp_start_line_and_header_splitter_core.sv
// Top level of the SSDP start line and header splitter.
//
// Bytes of a datagram enter on the s_ channel, one request per byte, with
// last_byte marking the final byte. Results leave on the m_ channel: one for
// the start line (accepted or rejected), one for each header line split into
// trimmed name and value, and an end-marked result for the final byte.
// Many bytes give no result at all.
// Each byte is parsed in the cycle it is accepted and its result, if any,
// appears in the output register on the next cycle, and a new byte is
// taken every cycle while the output side keeps up.
// The output register is the only buffer: while it holds a result that the
// receiver has not taken, s_ready is low and input is held off.
// Synchronous reset clears the parse state to wait for a start line and
// empties the output register; the final byte of a datagram does the same
// to the parse state. Bytes beyond MAX_DATAGRAM_BYTES are ignored.
module ssdp_start_line_and_header_splitter_core #(
    parameter int MAX_DATAGRAM_BYTES = ssdps_pkg::DEFAULT_MAX_DATAGRAM_BYTES
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ssdps_pkg::in_t  s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output ssdps_pkg::out_t m_result
);

    ssdps_pkg::step_t step;
    logic             accept;
    logic             m_valid_reg, m_valid_next;
    ssdps_pkg::out_t  m_result_reg, m_result_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    ssdps_line_parser #(
        .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .item    (s_item),
        .step    (step)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (accept) begin
            m_valid_next = step.made;
            if (step.made) begin
                m_result_next = step.res;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_last_gives_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.last_byte) |=> (m_valid && m_result.end_of_datagram))
        else $error("final byte did not produce an end-marked result");

    a_reject_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.kind == ssdps_pkg::KIND_START_REJECT) |->
        (m_result.message_kind == ssdps_pkg::MSG_NOTIFY))
        else $error("rejected start line carries a message kind");

    a_fields_header_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.kind != ssdps_pkg::KIND_HEADER) |->
        (m_result.name_length == '0 && m_result.value_length == '0))
        else $error("name or value length on a non-header result");

endmodule
